FILE: src/r2fft_pkg.sv
// r2fft_pkg: shared sizes, types and the twiddle ROM of the radix-2 FFT engine.
// No dependencies.
package r2fft_pkg;

    localparam int POINTS      = 64;
    localparam int LOG2_POINTS = 6;
    localparam int HALF_POINTS = POINTS / 2;
    localparam int SAMPLE_BITS = 16;
    localparam int BIN_BITS    = 22;
    localparam int TW_BITS     = 16;
    localparam int TW_FRAC     = 15;
    localparam int WORD_BITS   = 2 * BIN_BITS;
    localparam int BANK_AW     = LOG2_POINTS - 1;
    localparam int STAGE_BITS  = 3;

    typedef logic [LOG2_POINTS-1:0]        t_idx;
    typedef logic [BANK_AW-1:0]            t_bank_addr;
    typedef logic [WORD_BITS-1:0]          t_word;

    function automatic t_idx bit_rev(input t_idx v);
        t_idx r;
        for (int i = 0; i < LOG2_POINTS; i++) begin
            r[LOG2_POINTS-1-i] = v[i];
        end
        return r;
    endfunction

    // Q1.15 {cos, sin} of 2*pi*k/64, rounded to nearest; +1.0 clamps to 32767
    function automatic logic [2*TW_BITS-1:0] tw_entry(input t_bank_addr k);
        case (k)
            5'd0:    tw_entry = {16'sd32767, 16'sd0};
            5'd1:    tw_entry = {16'sd32610, 16'sd3212};
            5'd2:    tw_entry = {16'sd32138, 16'sd6393};
            5'd3:    tw_entry = {16'sd31357, 16'sd9512};
            5'd4:    tw_entry = {16'sd30274, 16'sd12540};
            5'd5:    tw_entry = {16'sd28899, 16'sd15447};
            5'd6:    tw_entry = {16'sd27246, 16'sd18205};
            5'd7:    tw_entry = {16'sd25330, 16'sd20788};
            5'd8:    tw_entry = {16'sd23170, 16'sd23170};
            5'd9:    tw_entry = {16'sd20788, 16'sd25330};
            5'd10:   tw_entry = {16'sd18205, 16'sd27246};
            5'd11:   tw_entry = {16'sd15447, 16'sd28899};
            5'd12:   tw_entry = {16'sd12540, 16'sd30274};
            5'd13:   tw_entry = {16'sd9512,  16'sd31357};
            5'd14:   tw_entry = {16'sd6393,  16'sd32138};
            5'd15:   tw_entry = {16'sd3212,  16'sd32610};
            5'd16:   tw_entry = {16'sd0,     16'sd32767};
            5'd17:   tw_entry = {-16'sd3212,  16'sd32610};
            5'd18:   tw_entry = {-16'sd6393,  16'sd32138};
            5'd19:   tw_entry = {-16'sd9512,  16'sd31357};
            5'd20:   tw_entry = {-16'sd12540, 16'sd30274};
            5'd21:   tw_entry = {-16'sd15447, 16'sd28899};
            5'd22:   tw_entry = {-16'sd18205, 16'sd27246};
            5'd23:   tw_entry = {-16'sd20788, 16'sd25330};
            5'd24:   tw_entry = {-16'sd23170, 16'sd23170};
            5'd25:   tw_entry = {-16'sd25330, 16'sd20788};
            5'd26:   tw_entry = {-16'sd27246, 16'sd18205};
            5'd27:   tw_entry = {-16'sd28899, 16'sd15447};
            5'd28:   tw_entry = {-16'sd30274, 16'sd12540};
            5'd29:   tw_entry = {-16'sd31357, 16'sd9512};
            5'd30:   tw_entry = {-16'sd32138, 16'sd6393};
            5'd31:   tw_entry = {-16'sd32610, 16'sd3212};
            default: tw_entry = '0;
        endcase
    endfunction

endpackage

FILE: src/r2fft_bfly.sv
// r2fft_bfly: butterfly datapath, registered products then round and add/sub.
// Depends on r2fft_pkg.
module r2fft_bfly (
    input  logic                     i_clk,
    input  r2fft_pkg::t_word         i_a,
    input  r2fft_pkg::t_word         i_b,
    input  logic signed [15:0]       i_wr,
    input  logic signed [15:0]       i_wi,
    output r2fft_pkg::t_word         o_sum,
    output r2fft_pkg::t_word         o_dif
);
    import r2fft_pkg::*;

    localparam int PROD_BITS = BIN_BITS + TW_BITS;
    localparam int ACC_BITS  = PROD_BITS + 2;

    logic signed [PROD_BITS-1:0] r_rr, r_ii, r_ri, r_ir;
    logic signed [BIN_BITS-1:0]  r_ar, r_ai;
    logic signed [BIN_BITS-1:0]  br, bi;
    logic signed [ACC_BITS-1:0]  acc_re, acc_im;
    logic signed [ACC_BITS-1:0]  pr, pim;

    assign br = i_b[WORD_BITS-1:BIN_BITS];
    assign bi = i_b[BIN_BITS-1:0];

    always_ff @(posedge i_clk) begin
        r_rr <= br * i_wr;
        r_ii <= bi * i_wi;
        r_ri <= br * i_wi;
        r_ir <= bi * i_wr;
        r_ar <= i_a[WORD_BITS-1:BIN_BITS];
        r_ai <= i_a[BIN_BITS-1:0];
    end

    always_comb begin
        acc_re = ACC_BITS'(r_rr) - ACC_BITS'(r_ii) + ACC_BITS'(1 << (TW_FRAC - 1));
        acc_im = ACC_BITS'(r_ri) + ACC_BITS'(r_ir) + ACC_BITS'(1 << (TW_FRAC - 1));
        pr     = acc_re >>> TW_FRAC;
        pim    = acc_im >>> TW_FRAC;
        // stored words wrap to 22 bits
        o_sum  = {BIN_BITS'(ACC_BITS'(r_ar) + pr), BIN_BITS'(ACC_BITS'(r_ai) + pim)};
        o_dif  = {BIN_BITS'(ACC_BITS'(r_ar) - pr), BIN_BITS'(ACC_BITS'(r_ai) - pim)};
    end

endmodule

FILE: src/radix2_fft_engine_core.sv
// radix2_fft_engine_core: 64-point radix-2 DIT FFT/IFFT, top level.
// Depends on r2fft_pkg and r2fft_bfly.
// Flow: the 64 input words load, then the six butterfly stages run (one
// butterfly a cycle, pipeline drained between stages), then the 64 bins leave
// one by one when not stalled, each read from the work memory and then registered.
// A new frame is accepted only after the last bin has been read out.
// Reset (synchronous, active low) clears control and the mode; memory is not cleared.
module radix2_fft_engine_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_inverse_mode_we,
    input  logic                  i_inverse_mode,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_sample_real,
    input  logic signed [15:0]    i_sample_imag,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [21:0]    o_bin_real,
    output logic signed [21:0]    o_bin_imag,
    output logic                  o_last_bin
);
    import r2fft_pkg::*;

    typedef enum logic [1:0] {S_LOAD, S_CALC, S_DRAIN, S_OUT} t_state;

    // Work buffer is split in two banks by the parity of the index, so the
    // two legs of any butterfly (indices differing in one bit) sit in
    // different banks. Within a bank the entry is the index without bit 0.
    t_word mem0 [HALF_POINTS];
    t_word mem1 [HALF_POINTS];

    t_state                 r_state;
    t_idx                   r_load_cnt;
    logic                   r_mode, r_inv;
    logic [STAGE_BITS-1:0]  r_stage;
    logic [BANK_AW-1:0]     r_bf;
    // pipeline: st1 = read data ready, st2 = products ready / write back
    logic                   r_st1_v, r_st2_v;
    t_idx                   r_st1_u, r_st1_w, r_st2_u, r_st2_w;
    logic                   r_st1_ub;
    logic signed [15:0]     r_wr, r_wi;
    t_word                  r_rd0, r_rd1;
    t_idx                   r_out_cnt;
    logic                   r_rd_pend, r_out_bank;
    logic                   r_out_valid, r_last;
    logic signed [21:0]     r_bin_re, r_bin_im;

    logic                   in_acc, issue, out_rd, out_take;
    logic                   we0, we1, re0, re1;
    t_bank_addr             wa0, wa1, ra0, ra1;
    t_word                  wd0, wd1, bf_a, bf_b, bf_sum, bf_dif, rd_sel;
    t_idx                   ld_addr, bf_u, bf_v, lo_mask;
    logic [BANK_AW-1:0]     tw_k;
    logic [2*TW_BITS-1:0]   tw;
    logic signed [21:0]     sh_re, sh_im;

    assign in_acc   = i_in_valid && (r_state == S_LOAD);
    assign issue    = (r_state == S_CALC);
    assign out_rd   = (r_state == S_OUT) && !r_rd_pend;
    assign out_take = (r_state == S_OUT) && r_rd_pend && (!r_out_valid || !i_out_stall);
    assign ld_addr  = bit_rev(r_load_cnt);

    // butterfly addresses: insert a zero at bit 'stage' of the counter
    always_comb begin
        lo_mask = t_idx'((1 << r_stage) - 1);
        bf_u    = ((t_idx'(r_bf) & ~lo_mask) << 1) | (t_idx'(r_bf) & lo_mask);
        bf_v    = bf_u | t_idx'(1 << r_stage);
        tw_k    = BANK_AW'((t_idx'(r_bf) & lo_mask) << (BANK_AW - r_stage));
        tw      = tw_entry(tw_k);
    end

    // memory port steering
    always_comb begin
        we0 = 1'b0; we1 = 1'b0;
        wa0 = '0;   wa1 = '0;
        wd0 = '0;   wd1 = '0;
        re0 = 1'b0; re1 = 1'b0;
        ra0 = '0;   ra1 = '0;
        if (in_acc) begin
            wd0 = {BIN_BITS'(i_sample_real), BIN_BITS'(i_sample_imag)};
            wd1 = wd0;
            wa0 = ld_addr[LOG2_POINTS-1:1];
            wa1 = wa0;
            we0 = !(^ld_addr);
            we1 = ^ld_addr;
        end else if (r_st2_v) begin
            if (^r_st2_u) begin
                we1 = 1'b1; wa1 = r_st2_u[LOG2_POINTS-1:1]; wd1 = bf_sum;
                we0 = 1'b1; wa0 = r_st2_w[LOG2_POINTS-1:1]; wd0 = bf_dif;
            end else begin
                we0 = 1'b1; wa0 = r_st2_u[LOG2_POINTS-1:1]; wd0 = bf_sum;
                we1 = 1'b1; wa1 = r_st2_w[LOG2_POINTS-1:1]; wd1 = bf_dif;
            end
        end
        if (issue) begin
            re0 = 1'b1; re1 = 1'b1;
            if (^bf_u) begin
                ra1 = bf_u[LOG2_POINTS-1:1];
                ra0 = bf_v[LOG2_POINTS-1:1];
            end else begin
                ra0 = bf_u[LOG2_POINTS-1:1];
                ra1 = bf_v[LOG2_POINTS-1:1];
            end
        end else if (out_rd) begin
            re0 = 1'b1; re1 = 1'b1;
            ra0 = r_out_cnt[LOG2_POINTS-1:1];
            ra1 = ra0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we0) mem0[wa0] <= wd0;
        if (re0) r_rd0 <= mem0[ra0];
    end

    always_ff @(posedge i_clk) begin
        if (we1) mem1[wa1] <= wd1;
        if (re1) r_rd1 <= mem1[ra1];
    end

    assign bf_a = r_st1_ub ? r_rd1 : r_rd0;
    assign bf_b = r_st1_ub ? r_rd0 : r_rd1;

    r2fft_bfly u_bfly (
        .i_clk (i_clk),
        .i_a   (bf_a),
        .i_b   (bf_b),
        .i_wr  (r_wr),
        .i_wi  (r_wi),
        .o_sum (bf_sum),
        .o_dif (bf_dif)
    );

    // output word: inverse scales by 1/N with an arithmetic shift
    always_comb begin
        rd_sel = r_out_bank ? r_rd1 : r_rd0;
        sh_re  = rd_sel[WORD_BITS-1:BIN_BITS];
        sh_im  = rd_sel[BIN_BITS-1:0];
        if (r_inv) begin
            sh_re = sh_re >>> LOG2_POINTS;
            sh_im = sh_im >>> LOG2_POINTS;
        end
    end

    // pipeline and payload registers
    always_ff @(posedge i_clk) begin
        r_st1_u  <= bf_u;
        r_st1_w  <= bf_v;
        r_st1_ub <= ^bf_u;
        r_wr     <= signed'(tw[2*TW_BITS-1:TW_BITS]);
        r_wi     <= r_inv ? signed'(tw[TW_BITS-1:0]) : -signed'(tw[TW_BITS-1:0]);
        r_st2_u  <= r_st1_u;
        r_st2_w  <= r_st1_w;
        if (out_rd) r_out_bank <= ^r_out_cnt;
        if (out_take) begin
            r_bin_re <= sh_re;
            r_bin_im <= sh_im;
            r_last   <= (r_out_cnt == t_idx'(POINTS - 1));
        end
    end

    // control state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load_cnt  <= '0;
            r_mode      <= 1'b0;
            r_inv       <= 1'b0;
            r_stage     <= '0;
            r_bf        <= '0;
            r_st1_v     <= 1'b0;
            r_st2_v     <= 1'b0;
            r_out_cnt   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_inverse_mode_we) r_mode <= i_inverse_mode;
            r_st1_v <= issue;
            r_st2_v <= r_st1_v;
            // a new bin word replaces the one leaving this cycle
            if (out_take) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_load_cnt <= r_load_cnt + 1'b1;
                        if (r_load_cnt == t_idx'(POINTS - 1)) begin
                            r_inv   <= r_mode;
                            r_stage <= '0;
                            r_bf    <= '0;
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    r_bf <= r_bf + 1'b1;
                    if (r_bf == BANK_AW'(HALF_POINTS - 1)) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    // next stage reads only after every write of this one
                    if (!r_st1_v && !r_st2_v) begin
                        if (r_stage == STAGE_BITS'(LOG2_POINTS - 1)) begin
                            r_out_cnt <= '0;
                            r_rd_pend <= 1'b0;
                            r_state   <= S_OUT;
                        end else begin
                            r_stage <= r_stage + 1'b1;
                            r_bf    <= '0;
                            r_state <= S_CALC;
                        end
                    end
                end
                S_OUT: begin
                    if (out_rd) r_rd_pend <= 1'b1;
                    if (out_take) begin
                        r_rd_pend   <= 1'b0;
                        r_out_cnt   <= r_out_cnt + 1'b1;
                        if (r_out_cnt == t_idx'(POINTS - 1)) r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_bin_real  = r_bin_re;
    assign o_bin_imag  = r_bin_im;
    assign o_last_bin  = r_last;

endmodule
